### rtl/core/sdcc_pkg.sv
// Package for the segment deframer with checksum check.
// Constants, register map and the result record shared by the parser and the top level.
// No dependencies.
package sdcc_pkg;

    localparam int MAX_PAYLOAD_DEF   = 512;
    localparam int MAX_PAYLOAD_RESET = 500;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_ADDR_W        = 3;
    localparam int MAX_PAYLOAD_W     = 10;

    // header byte positions
    localparam logic [3:0] HDR_TYPE      = 4'd0;
    localparam logic [3:0] HDR_LEN_LAST  = 4'd4;
    localparam logic [3:0] HDR_SEQ_FIRST = 4'd5;
    localparam logic [3:0] HDR_SEQ_LAST  = 4'd8;
    localparam logic [3:0] HDR_CHK_FIRST = 4'd9;
    localparam logic [3:0] HDR_LAST      = 4'd12;
    localparam logic [3:0] PAYLOAD_PHASE = 4'd13;

    // register index (byte address / 4)
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        has_payload;
        logic        end_of_segment;
        logic        corrupt;
        logic        too_long;
        logic [7:0]  segment_type;
        logic [31:0] segment_length;
        logic [31:0] sequence_number;
    } result_t;

endpackage

### rtl/core/sdcc_parser.sv
// Header parser, payload counter and running checksum for the segment deframer.
// Produces at most one result record per accepted request.
// Depends on sdcc_pkg.
module sdcc_parser #(
    parameter int MAX_PAYLOAD = sdcc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              take,
    input  logic [7:0]                        rx_byte,
    input  logic [sdcc_pkg::MAX_PAYLOAD_W-1:0] max_payload,
    output logic                              produce,
    output sdcc_pkg::result_t                 result
);
    import sdcc_pkg::*;

    localparam int REM_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [31:0] MAX_PAYLOAD_32 = 32'(MAX_PAYLOAD);

    logic [3:0]       index_reg, index_next;
    logic [7:0]       type_reg, type_next;
    logic [31:0]      length_reg, length_next;
    logic [31:0]      seq_reg, seq_next;
    logic [31:0]      chk_reg, chk_next;
    logic [31:0]      sum_reg, sum_next;
    logic [REM_W-1:0] rem_reg, rem_next;

    logic [REM_W-1:0] rem_dec;
    logic [31:0]      limit;
    logic [31:0]      max_payload_32;

    assign max_payload_32 = 32'(max_payload);
    assign limit   = (max_payload_32 < MAX_PAYLOAD_32) ? max_payload_32 : MAX_PAYLOAD_32;
    assign rem_dec = (rem_reg != '0) ? rem_reg - 1'b1 : '0;

    always_comb begin
        index_next  = index_reg;
        type_next   = type_reg;
        length_next = length_reg;
        seq_next    = seq_reg;
        chk_next    = chk_reg;
        sum_next    = sum_reg;
        rem_next    = rem_reg;
        produce     = 1'b0;

        result                 = '0;
        result.segment_type    = type_reg;
        result.segment_length  = length_reg;
        result.sequence_number = seq_reg;

        if (take) begin
            if (index_reg >= PAYLOAD_PHASE) begin
                sum_next            = sum_reg + 32'(rx_byte);
                rem_next            = rem_dec;
                produce             = 1'b1;
                result.payload_byte = rx_byte;
                result.has_payload  = 1'b1;
                if (rem_dec == '0) begin
                    index_next            = HDR_TYPE;
                    result.end_of_segment = 1'b1;
                    result.corrupt        = (sum_next != '1);
                end
            end else begin
                if (index_reg == HDR_TYPE) begin
                    type_next = rx_byte;
                end else if (index_reg <= HDR_LEN_LAST) begin
                    length_next = {length_reg[23:0], rx_byte};
                end else if (index_reg <= HDR_SEQ_LAST) begin
                    seq_next = {seq_reg[23:0], rx_byte};
                end else begin
                    chk_next = {chk_reg[23:0], rx_byte};
                end

                // spread the header sum over three header bytes, one add at each
                if (index_reg == HDR_SEQ_FIRST) begin
                    sum_next = 32'(type_reg) + length_reg;
                end else if (index_reg == HDR_CHK_FIRST) begin
                    sum_next = sum_reg + seq_reg;
                end else if (index_reg == HDR_LAST) begin
                    sum_next = sum_reg + chk_next;
                end

                if (index_reg < HDR_LAST) begin
                    index_next = index_reg + 1'b1;
                end else if (length_reg > limit) begin
                    index_next            = HDR_TYPE;
                    rem_next              = '0;
                    produce               = 1'b1;
                    result.end_of_segment = 1'b1;
                    result.too_long       = 1'b1;
                end else if (length_reg == '0) begin
                    index_next            = HDR_TYPE;
                    rem_next              = '0;
                    produce               = 1'b1;
                    result.end_of_segment = 1'b1;
                    result.corrupt        = (sum_next != '1);
                end else begin
                    index_next = PAYLOAD_PHASE;
                    rem_next   = length_reg[REM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= HDR_TYPE;
            rem_reg   <= '0;
        end else begin
            index_reg <= index_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg   <= type_next;
        length_reg <= length_next;
        seq_reg    <= seq_next;
        chk_reg    <= chk_next;
        sum_reg    <= sum_next;
    end

endmodule

### rtl/core/segment_deframer_checksum_check_core.sv
// Segment deframer with additive checksum check: one byte per request in, one
// result per payload byte or header-ended segment; one request per cycle if drained.
// Depends on sdcc_pkg and sdcc_parser.
//
// Takes one byte per cycle while the output is drained: each byte goes through the
// combinational parser and its result, if any, lands in a single output
// register, so a new request is taken whenever that register is empty or
// being drained. An accepted byte's result is valid in the cycle after it is taken.
// A segment is a 13-byte header (type, big-endian length, sequence,
// checksum) followed by length payload bytes. Header bytes give no result
// except the last one, which closes the segment when the length is zero or
// exceeds min(max_payload, MAX_PAYLOAD). max_payload sits at byte address 0
// and must only be written while the block is idle.
module segment_deframer_checksum_check_core #(
    parameter int MAX_PAYLOAD = sdcc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_rx_byte,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_payload_byte,
    output logic                               m_has_payload,
    output logic                               m_end_of_segment,
    output logic                               m_corrupt,
    output logic                               m_too_long,
    output logic [7:0]                         m_segment_type,
    output logic [31:0]                        m_segment_length,
    output logic [31:0]                        m_sequence_number,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sdcc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [sdcc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [sdcc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import sdcc_pkg::*;

    logic [MAX_PAYLOAD_W-1:0] max_payload_reg, max_payload_next;
    logic                     m_valid_reg, m_valid_next;
    result_t                  out_reg, out_next;

    logic    take;
    logic    produce;
    result_t result;
    logic    reg_sel;

    // configuration port
    assign pready  = 1'b1;
    assign reg_sel = paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W-2)'(REG_MAX_PAYLOAD);
    assign prdata  = reg_sel ? CFG_DATA_W'(max_payload_reg) : '0;

    always_comb begin
        max_payload_next = max_payload_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            max_payload_next = pwdata[MAX_PAYLOAD_W-1:0];
        end
    end

    // request side
    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    sdcc_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .rx_byte     (s_rx_byte),
        .max_payload (max_payload_reg),
        .produce     (produce),
        .result      (result)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (produce) begin
            m_valid_next = 1'b1;
            out_next     = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_W'(MAX_PAYLOAD_RESET);
            m_valid_reg     <= 1'b0;
        end else begin
            max_payload_reg <= max_payload_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_payload_byte    = out_reg.payload_byte;
    assign m_has_payload     = out_reg.has_payload;
    assign m_end_of_segment  = out_reg.end_of_segment;
    assign m_corrupt         = out_reg.corrupt;
    assign m_too_long        = out_reg.too_long;
    assign m_segment_type    = out_reg.segment_type;
    assign m_segment_length  = out_reg.segment_length;
    assign m_sequence_number = out_reg.sequence_number;

endmodule
